[rtl/core/pgra_pkg.sv]
// Shared constants, stage types and arithmetic helpers for the polygon area pipeline.
`default_nettype none

package pgra_pkg;

  localparam int COORD_BITS    = 16;
  localparam int COUNT_BITS    = 16;
  localparam int FIELD_BITS    = 16;
  localparam int TOTAL_BITS    = 16;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int CROSS_BITS    = 2 * COORD_BITS;
  localparam int TERM_BITS     = CROSS_BITS + 1;
  localparam int DPROD_BITS    = 2 * DIFF_BITS;
  localparam int DOT_BITS      = DPROD_BITS + 1;
  localparam int AREA_BITS     = 50;
  localparam int OUT_AREA_BITS = 48;
  localparam int S_DATA_BITS   = 2 * FIELD_BITS;
  localparam int M_RAW_BITS    = OUT_AREA_BITS + 1 + TOTAL_BITS;
  localparam int M_DATA_BITS   = ((M_RAW_BITS + 7) / 8) * 8;
  localparam int PAD_BITS      = M_DATA_BITS - M_RAW_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE    = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] MIN_VERTICES = COUNT_BITS'(3);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic signed [TERM_BITS-1:0]  term_t;
  typedef logic signed [DPROD_BITS-1:0] dprod_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;
  typedef logic signed [AREA_BITS-1:0]  area_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  localparam area_t AREA_MAX = {1'b0, {(AREA_BITS-1){1'b1}}};
  localparam area_t AREA_MIN = {1'b1, {(AREA_BITS-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  typedef struct packed {
    logic    last;
    logic    too_few;
    logic    no_prev;
    logic    chk_mid;
    count_t  total;
    vertex_t cur;
    vertex_t prev;
    vertex_t first;
    vec_t    a_mid;
    vec_t    b_mid;
    vec_t    a_last;
    vec_t    b_last;
    vec_t    a_first;
    vec_t    b_first;
  } front_t;

  typedef struct packed {
    logic   last;
    logic   too_few;
    logic   no_prev;
    logic   chk_mid;
    count_t total;
    cross_t c1p;
    cross_t c1n;
    cross_t c2p;
    cross_t c2n;
    dprod_t m_x;
    dprod_t m_y;
    dprod_t l_x;
    dprod_t l_y;
    dprod_t f_x;
    dprod_t f_y;
  } prod_t;

  typedef struct packed {
    logic   last;
    logic   too_few;
    count_t total;
    term_t  t_step;
    term_t  t_wrap;
    logic   right_mid;
    logic   right_end;
  } term_item_t;

  typedef struct packed {
    logic   too_few;
    count_t total;
    logic   right;
    area_t  sum;
    term_t  t_wrap;
  } close_t;

  typedef struct packed {
    logic   too_few;
    count_t total;
    logic   right;
    area_t  sum;
  } final_t;

  function automatic vec_t vec_between(vertex_t to_v, vertex_t from_v);
    vec_t d;
    d.x = DIFF_BITS'(to_v.x) - DIFF_BITS'(from_v.x);
    d.y = DIFF_BITS'(to_v.y) - DIFF_BITS'(from_v.y);
    return d;
  endfunction

  function automatic area_t sat_add(area_t acc, term_t term);
    logic signed [AREA_BITS:0] s;
    s = (AREA_BITS+1)'(acc) + (AREA_BITS+1)'(term);
    if (s[AREA_BITS] != s[AREA_BITS-1]) begin
      return s[AREA_BITS] ? AREA_MIN : AREA_MAX;
    end
    return s[AREA_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/pgra_front.sv]
// Input stage: vertex history, vertex count and edge vector registers.
`default_nettype none

module pgra_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pgra_pkg::S_DATA_BITS-1:0]     s_tdata,
  input  logic                                 s_tlast,
  output logic                                 f_valid,
  input  logic                                 f_ready,
  output pgra_pkg::front_t                     f_data
);
  import pgra_pkg::*;

  vertex_t first;
  vertex_t second;
  vertex_t prev;
  vertex_t prev2;
  count_t  count;
  count_t  count_next;
  vertex_t cur;
  logic    no_prev;
  logic    one_seen;
  logic    take;

  assign s_tready   = !f_valid || f_ready;
  assign take       = s_tvalid && s_tready;
  assign cur.x      = coord_t'(s_tdata[COORD_BITS-1:0]);
  assign cur.y      = coord_t'(s_tdata[FIELD_BITS +: COORD_BITS]);
  assign no_prev    = (count == '0);
  assign one_seen   = (count == COUNT_ONE);
  assign count_next = (count != COUNT_MAX) ? count + COUNT_ONE : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      f_valid <= 1'b0;
    end else begin
      if (take) begin
        count <= s_tlast ? '0 : count_next;
      end
      if (s_tready) begin
        f_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (no_prev) begin
        first <= cur;
      end
      if (one_seen) begin
        second <= cur;
      end
      prev2 <= prev;
      prev  <= cur;
      f_data.last    <= s_tlast;
      f_data.too_few <= (count_next < MIN_VERTICES);
      f_data.no_prev <= no_prev;
      f_data.chk_mid <= !no_prev && !one_seen;
      f_data.total   <= count_next;
      f_data.cur     <= cur;
      f_data.prev    <= prev;
      f_data.first   <= first;
      f_data.a_mid   <= vec_between(prev2, prev);
      f_data.b_mid   <= vec_between(cur, prev);
      f_data.a_last  <= vec_between(prev, cur);
      f_data.b_last  <= vec_between(first, cur);
      f_data.a_first <= vec_between(cur, first);
      f_data.b_first <= vec_between(second, first);
    end
  end

`ifndef SYNTHESIS
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (count == '0))
    else $error("vertex count not cleared after final vertex");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (f_data.total != '0))
    else $error("staged vertex carries a zero count");
`endif

endmodule

`default_nettype wire

[rtl/core/pgra_mult.sv]
// Product stage and term stage: cross products and dot product zero tests.
`default_nettype none

module pgra_mult (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   f_valid,
  output logic                   f_ready,
  input  pgra_pkg::front_t       f_data,
  output logic                   t_valid,
  input  logic                   t_ready,
  output pgra_pkg::term_item_t   t_data
);
  import pgra_pkg::*;

  prod_t p_reg;
  logic  p_valid;
  logic  t_load;
  dot_t  dot_mid;
  dot_t  dot_last;
  dot_t  dot_first;
  term_t step_term;

  assign t_load   = !t_valid || t_ready;
  assign f_ready  = !p_valid || t_load;

  assign dot_mid   = DOT_BITS'(p_reg.m_x) + DOT_BITS'(p_reg.m_y);
  assign dot_last  = DOT_BITS'(p_reg.l_x) + DOT_BITS'(p_reg.l_y);
  assign dot_first = DOT_BITS'(p_reg.f_x) + DOT_BITS'(p_reg.f_y);
  assign step_term = TERM_BITS'(p_reg.c1p) - TERM_BITS'(p_reg.c1n);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      t_valid <= 1'b0;
    end else begin
      if (f_ready) begin
        p_valid <= f_valid;
      end
      if (t_load) begin
        t_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid && f_ready) begin
      p_reg.last    <= f_data.last;
      p_reg.too_few <= f_data.too_few;
      p_reg.no_prev <= f_data.no_prev;
      p_reg.chk_mid <= f_data.chk_mid;
      p_reg.total   <= f_data.total;
      p_reg.c1p     <= CROSS_BITS'(f_data.prev.x) * CROSS_BITS'(f_data.cur.y);
      p_reg.c1n     <= CROSS_BITS'(f_data.prev.y) * CROSS_BITS'(f_data.cur.x);
      p_reg.c2p     <= CROSS_BITS'(f_data.cur.x) * CROSS_BITS'(f_data.first.y);
      p_reg.c2n     <= CROSS_BITS'(f_data.cur.y) * CROSS_BITS'(f_data.first.x);
      p_reg.m_x     <= DPROD_BITS'(f_data.a_mid.x) * DPROD_BITS'(f_data.b_mid.x);
      p_reg.m_y     <= DPROD_BITS'(f_data.a_mid.y) * DPROD_BITS'(f_data.b_mid.y);
      p_reg.l_x     <= DPROD_BITS'(f_data.a_last.x) * DPROD_BITS'(f_data.b_last.x);
      p_reg.l_y     <= DPROD_BITS'(f_data.a_last.y) * DPROD_BITS'(f_data.b_last.y);
      p_reg.f_x     <= DPROD_BITS'(f_data.a_first.x) * DPROD_BITS'(f_data.b_first.x);
      p_reg.f_y     <= DPROD_BITS'(f_data.a_first.y) * DPROD_BITS'(f_data.b_first.y);
    end
    if (p_valid && t_load) begin
      t_data.last      <= p_reg.last;
      t_data.too_few   <= p_reg.too_few;
      t_data.total     <= p_reg.total;
      t_data.t_step    <= p_reg.no_prev ? '0 : step_term;
      t_data.t_wrap    <= TERM_BITS'(p_reg.c2p) - TERM_BITS'(p_reg.c2n);
      t_data.right_mid <= p_reg.chk_mid && (dot_mid == '0);
      t_data.right_end <= p_reg.last && !p_reg.too_few &&
                          ((dot_last == '0) || (dot_first == '0));
    end
  end

endmodule

`default_nettype wire

[rtl/core/pgra_accum.sv]
// Shoelace accumulator, wrap-around close, magnitude and result register.
`default_nettype none

module pgra_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 t_valid,
  output logic                                 t_ready,
  input  pgra_pkg::term_item_t                 t_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pgra_pkg::M_DATA_BITS-1:0]     m_tdata,
  output logic                                 m_tuser
);
  import pgra_pkg::*;

  area_t  sum;
  logic   right_seen;
  area_t  sum_step;
  logic   right_step;
  close_t c_reg;
  logic   c_valid;
  final_t fin;
  logic   fin_valid;
  logic   fin_load;
  logic   out_load;
  logic signed [AREA_BITS:0] wide;
  logic [AREA_BITS:0]        mag;
  logic [OUT_AREA_BITS-1:0]  area_out;

  assign out_load   = !m_tvalid || m_tready;
  assign fin_load   = !fin_valid || out_load;
  assign t_ready    = !c_valid || fin_load;
  assign sum_step   = sat_add(sum, t_data.t_step);
  assign right_step = right_seen || t_data.right_mid;

  assign wide     = (AREA_BITS+1)'(fin.sum);
  assign mag      = wide[AREA_BITS] ? $unsigned(-wide) : $unsigned(wide);
  assign area_out = (|mag[AREA_BITS:OUT_AREA_BITS]) ? '1 : mag[OUT_AREA_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      right_seen <= 1'b0;
      c_valid    <= 1'b0;
      fin_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (t_valid && t_ready) begin
        sum        <= t_data.last ? '0 : sum_step;
        right_seen <= t_data.last ? 1'b0 : right_step;
      end
      if (t_ready) begin
        c_valid <= t_valid && t_data.last;
      end
      if (fin_load) begin
        fin_valid <= c_valid;
      end
      if (out_load) begin
        m_tvalid <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t_valid && t_ready && t_data.last) begin
      c_reg.too_few <= t_data.too_few;
      c_reg.total   <= t_data.total;
      c_reg.right   <= right_step || t_data.right_end;
      c_reg.sum     <= sum_step;
      c_reg.t_wrap  <= t_data.t_wrap;
    end
    if (c_valid && fin_load) begin
      fin.too_few <= c_reg.too_few;
      fin.total   <= c_reg.total;
      fin.right   <= c_reg.right;
      fin.sum     <= sat_add(c_reg.sum, c_reg.t_wrap);
    end
    if (fin_valid && out_load) begin
      m_tdata <= {{PAD_BITS{1'b0}},
                  TOTAL_BITS'(fin.total),
                  fin.right && !fin.too_few,
                  fin.too_few ? {OUT_AREA_BITS{1'b0}} : area_out};
      m_tuser <= fin.too_few;
    end
  end

`ifndef SYNTHESIS
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (t_valid && t_ready && t_data.last) |=> (sum == '0 && !right_seen))
    else $error("accumulator not cleared after final vertex");

  a_short_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[OUT_AREA_BITS-1:0] == '0 && !m_tdata[OUT_AREA_BITS]))
    else $error("short polygon result carries area or right angle");
`endif

endmodule

`default_nettype wire

[rtl/core/polygon_area_right_angle.sv]
// Top level: streaming shoelace polygon area with right-angle detection.
// A final vertex passes front, product, term, close, final and output registers.
// One vertex per cycle unless m_tready stalls; stages are valid/ready register slices.
// Each vertex costs one pass through the product registers and one accumulator add.
// Reset (rst, synchronous): clears the vertex count, accumulator and all valid flags.
`default_nettype none

module polygon_area_right_angle (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // vertex_x [15:0], vertex_y [31:16]
  input  logic [pgra_pkg::S_DATA_BITS-1:0]     s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // double_area [47:0], right_angle_found [48], vertex_total [64:49], zero pad [71:65]
  output logic [pgra_pkg::M_DATA_BITS-1:0]     m_tdata,
  // too_few_vertices [0]
  output logic                                 m_tuser
);
  import pgra_pkg::*;

  front_t     f_data;
  logic       f_valid;
  logic       f_ready;
  term_item_t t_data;
  logic       t_valid;
  logic       t_ready;

  pgra_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  pgra_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_data  (f_data),
    .t_valid (t_valid),
    .t_ready (t_ready),
    .t_data  (t_data)
  );

  pgra_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .t_valid  (t_valid),
    .t_ready  (t_ready),
    .t_data   (t_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
